[sv/bcu_pkg.sv]
package bcu_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_bcu_in;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_fault;
    } t_bcu_out;

    typedef struct packed {
        logic [47:0] ac_first;
        logic [47:0] ac_second;
        logic [31:0] b_pair;
        logic [31:0] m_pair;
        logic [1:0]  oversampling;
    } t_bcu_cal;

    typedef enum logic [2:0] {
        REG_AC_FIRST  = 3'd0,
        REG_AC_SECOND = 3'd1,
        REG_B_PAIR    = 3'd2,
        REG_M_PAIR    = 3'd3,
        REG_OSS       = 3'd4
    } t_bcu_reg;

    localparam logic [1:0]         OSS_RESET   = 2'd3;
    localparam logic signed [29:0] B6_OFFSET   = 30'sd4000;
    localparam logic signed [29:0] T_ROUND     = 30'sd8;
    localparam logic [31:0]        X3_OFFSET   = 32'd32768;
    localparam logic signed [13:0] Y2_COEF     = -14'sd7357;
    localparam logic signed [12:0] Y1_COEF     = 13'sd3038;
    localparam logic [35:0]        P_OFFSET    = 36'd3791;
    localparam logic signed [29:0] T_MAX       = 30'sd32767;
    localparam logic signed [29:0] T_MIN       = -30'sd32768;

    // 50000 >> oss
    function automatic logic [15:0] oss_scale(input logic [1:0] oss);
        logic [15:0] v;
        case (oss)
            2'd0:    v = 16'd50000;
            2'd1:    v = 16'd25000;
            2'd2:    v = 16'd12500;
            default: v = 16'd6250;
        endcase
        return v;
    endfunction

endpackage

[sv/barometer_compensation_unit.sv]
// DIV_STEP defaults to 4.
// Throughput: one transaction per cycle; every stage, including both divider pipelines,
// advances together whenever the output register is empty or being drained.
// The two dividers resolve DIV_STEP quotient bits per stage and set the depth.
// Reset (synchronous, active low) clears all valid bits and the calibration registers;
// oversampling returns to 3. Data registers are not reset.
module barometer_compensation_unit
    import bcu_pkg::*;
#(
    parameter int DIV_STEP = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_bcu_in     i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_bcu_out    o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_bcu_cal cal;

    bcu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (cal)
    );

    // Calibration words, unpacked once and shared by every stage
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [15:0] ac4, ac5, ac6;
    logic        [1:0]  oss;

    assign ac1 = cal.ac_first[47:32];
    assign ac2 = cal.ac_first[31:16];
    assign ac3 = cal.ac_first[15:0];
    assign ac4 = cal.ac_second[47:32];
    assign ac5 = cal.ac_second[31:16];
    assign ac6 = cal.ac_second[15:0];
    assign b1  = cal.b_pair[31:16];
    assign b2  = cal.b_pair[15:0];
    assign mc  = cal.m_pair[31:16];
    assign md  = cal.m_pair[15:0];
    assign oss = cal.oversampling;

    // Global advance: the whole pipe moves unless the output holds an untaken result
    logic en;
    logic r_out_vld;
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_vld;

    //------------------------------------------------------------------
    // Stage 1: (UT - AC6) * AC5, shift the raw pressure down
    //------------------------------------------------------------------
    logic               r1_vld;
    logic signed [34:0] r1_prod;
    logic        [18:0] r1_up;
    logic signed [17:0] w1_diff;
    logic        [23:0] w1_up;

    assign w1_diff = $signed({2'b0, i_data.raw_temperature}) - $signed({2'b0, ac6});
    assign w1_up   = i_data.raw_pressure >> (4'd8 - {2'b0, oss});

    //------------------------------------------------------------------
    // Stage 2: X1 and the temperature divisor X1 + MD
    //------------------------------------------------------------------
    logic               r2_vld;
    logic signed [19:0] r2_x1;
    logic signed [20:0] r2_den;
    logic               r2_fault;
    logic        [18:0] r2_up;
    logic signed [19:0] w2_x1;
    logic signed [20:0] w2_den;

    assign w2_x1  = r1_prod[34:15];
    assign w2_den = 21'(w2_x1) + 21'(md);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod  <= w1_diff * $signed({1'b0, ac5});
            r1_up    <= w1_up[18:0];
            r2_x1    <= w2_x1;
            r2_den   <= w2_den;
            r2_fault <= (w2_den == '0);
            r2_up    <= r1_up;
        end
    end

    //------------------------------------------------------------------
    // Divider 1: X2 = MC * 2048 / (X1 + MD), on magnitudes, sign fixed after
    //------------------------------------------------------------------
    localparam int D1_NW = 28;
    localparam int D1_DW = 20;
    localparam int D1_SW = 41;

    logic signed [16:0] w_mc_abs;
    logic signed [20:0] w_den_abs;
    logic [D1_NW-1:0]   d1_num;
    logic [D1_DW-1:0]   d1_den;
    logic [D1_SW-1:0]   d1_side_in, d1_side_out;
    logic [D1_NW-1:0]   d1_quo;
    logic               d1_vld;

    assign w_mc_abs   = mc[15] ? -17'(mc) : 17'(mc);
    assign w_den_abs  = r2_den[20] ? -r2_den : r2_den;
    assign d1_num     = {1'b0, w_mc_abs[15:0], 11'b0};
    assign d1_den     = w_den_abs[19:0];
    assign d1_side_in = {mc[15] ^ r2_den[20], r2_fault, r2_x1, r2_up};

    bcu_div #(
        .NW  (D1_NW),
        .DW  (D1_DW),
        .SW  (D1_SW),
        .BPS (DIV_STEP)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_side  (d1_side_in),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side_out)
    );

    logic               d1_neg, d1_fault;
    logic signed [19:0] d1_x1;
    logic        [18:0] d1_up;
    logic signed [28:0] w_x2;

    assign {d1_neg, d1_fault, d1_x1, d1_up} = d1_side_out;
    assign w_x2 = d1_neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});

    //------------------------------------------------------------------
    // Stage 3: B5 = X1 + X2
    // Stage 4: B6 and the saturated temperature
    // Stage 5: B6 * B6, AC2 * B6, AC3 * B6
    //------------------------------------------------------------------
    logic               r3_vld, r4_vld, r5_vld;
    logic signed [29:0] r3_b5;
    logic               r3_fault, r4_fault, r5_fault;
    logic        [18:0] r3_up, r4_up, r5_up;
    logic signed [29:0] r4_b6;
    logic signed [15:0] r4_t, r5_t;
    logic        [56:0] r5_sq;
    logic signed [47:0] r5_ac2, r5_ac3;
    logic signed [29:0] w4_t;
    logic signed [15:0] w4_sat;
    logic signed [59:0] w5_sq;

    assign w4_t  = (r3_b5 + T_ROUND) >>> 4;
    assign w5_sq = r4_b6 * r4_b6;

    always_comb begin
        if (w4_t > T_MAX) begin
            w4_sat = 16'sh7FFF;
        end else if (w4_t < T_MIN) begin
            w4_sat = -16'sh8000;
        end else begin
            w4_sat = w4_t[15:0];
        end
    end

    //------------------------------------------------------------------
    // Stage 6: split SQ = (B6*B6) >> 12 into halves for B2 and B1 products
    // Stage 7: recombine the halves, keep only the low bits that matter mod 2^32
    // Stage 8: B3 and X3 (pressure side), both reduced to 32 bits
    //------------------------------------------------------------------
    logic               r6_vld, r7_vld, r8_vld;
    logic               r6_fault, r7_fault, r8_fault;
    logic        [18:0] r6_up, r7_up, r8_up;
    logic signed [15:0] r6_t, r7_t, r8_t;
    logic signed [39:0] r6_b2h, r6_b1h;
    logic signed [38:0] r6_b2l, r6_b1l;
    logic        [33:0] r6_x1a, r6_x1c;
    logic        [33:0] r7_x1a, r7_x1c, r7_x1b, r7_x2b;
    logic        [31:0] r8_b3, r8_x3c;
    logic        [44:0] w6_sq;
    logic        [44:0] w7_s2;
    logic        [49:0] w7_s1;
    logic        [33:0] w8_sum;
    logic        [33:0] w8_b3w;
    logic        [33:0] w8_x3w;

    assign w6_sq  = r5_sq[56:12];
    assign w7_s2  = {r6_b2h[22:0], 22'b0} + 45'(r6_b2l);
    assign w7_s1  = {r6_b1h[27:0], 22'b0} + 50'(r6_b1l);
    // AC1 * 4, sign extended to the working width
    assign w8_sum = r7_x1a + r7_x1b + {{16{ac1[15]}}, ac1, 2'b0};
    assign w8_b3w = (w8_sum << oss) + 34'd2;
    assign w8_x3w = r7_x1c + r7_x2b + 34'd2;

    //------------------------------------------------------------------
    // Stage 9: UP - B3 and X3 + 32768
    // Stage 10: B7 and B4
    //------------------------------------------------------------------
    logic               r9_vld, r10_vld;
    logic               r9_fault, r10_fault;
    logic signed [15:0] r9_t, r10_t;
    logic        [31:0] r9_diff, r9_xs;
    logic        [31:0] r10_b7;
    logic        [16:0] r10_b4;
    logic        [47:0] w10_b7;
    logic        [47:0] w10_b4;

    assign w10_b7 = 48'(r9_diff) * 48'(oss_scale(oss));
    assign w10_b4 = 48'(ac4) * 48'(r9_xs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else if (en) begin
            r3_vld  <= d1_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_b5     <= 30'(d1_x1) + 30'(w_x2);
            r3_fault  <= d1_fault;
            r3_up     <= d1_up;

            r4_b6     <= r3_b5 - B6_OFFSET;
            r4_t      <= w4_sat;
            r4_fault  <= r3_fault;
            r4_up     <= r3_up;

            r5_sq     <= w5_sq[56:0];
            r5_ac2    <= 48'(ac2) * 48'(r4_b6);
            r5_ac3    <= 48'(ac3) * 48'(r4_b6);
            r5_t      <= r4_t;
            r5_fault  <= r4_fault;
            r5_up     <= r4_up;

            r6_b2h    <= b2 * $signed({1'b0, w6_sq[44:22]});
            r6_b2l    <= b2 * $signed({1'b0, w6_sq[21:0]});
            r6_b1h    <= b1 * $signed({1'b0, w6_sq[44:22]});
            r6_b1l    <= b1 * $signed({1'b0, w6_sq[21:0]});
            r6_x1a    <= r5_ac2[44:11];
            r6_x1c    <= r5_ac3[46:13];
            r6_t      <= r5_t;
            r6_fault  <= r5_fault;
            r6_up     <= r5_up;

            r7_x1a    <= r6_x1a;
            r7_x1c    <= r6_x1c;
            r7_x1b    <= w7_s2[44:11];
            r7_x2b    <= w7_s1[49:16];
            r7_t      <= r6_t;
            r7_fault  <= r6_fault;
            r7_up     <= r6_up;

            r8_b3     <= w8_b3w[33:2];
            r8_x3c    <= w8_x3w[33:2];
            r8_t      <= r7_t;
            r8_fault  <= r7_fault;
            r8_up     <= r7_up;

            r9_diff   <= 32'(r8_up) - r8_b3;
            r9_xs     <= r8_x3c + X3_OFFSET;
            r9_t      <= r8_t;
            r9_fault  <= r8_fault;

            r10_b7    <= w10_b7[31:0];
            r10_b4    <= w10_b4[31:15];
            r10_t     <= r9_t;
            r10_fault <= r9_fault;
        end
    end

    //------------------------------------------------------------------
    // Divider 2: P0 = B7 * 2 / B4, or (B7 / B4) * 2 when B7 has its top bit set
    //------------------------------------------------------------------
    localparam int D2_NW = 32;
    localparam int D2_DW = 17;
    localparam int D2_SW = 18;

    logic [D2_NW-1:0] d2_num, d2_quo;
    logic [D2_SW-1:0] d2_side_in, d2_side_out;
    logic             d2_vld;

    assign d2_num     = r10_b7[31] ? r10_b7 : {r10_b7[30:0], 1'b0};
    assign d2_side_in = {r10_b7[31], r10_fault || (r10_b4 == '0), r10_t};

    bcu_div #(
        .NW  (D2_NW),
        .DW  (D2_DW),
        .SW  (D2_SW),
        .BPS (DIV_STEP)
    ) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_vld),
        .i_num   (d2_num),
        .i_den   (r10_b4),
        .i_side  (d2_side_in),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side_out)
    );

    logic               d2_dbl, d2_fault;
    logic signed [15:0] d2_t;
    logic signed [31:0] w_p0;

    assign {d2_dbl, d2_fault, d2_t} = d2_side_out;
    assign w_p0 = d2_dbl ? {d2_quo[30:0], 1'b0} : d2_quo;

    //------------------------------------------------------------------
    // Stage 11: (P0 >> 8)^2 and -7357 * P0
    // Stage 12: scale by 3038 and drop 16 bits, keep the low 36 bits
    // Output: add the correction and register the result
    //------------------------------------------------------------------
    logic               r11_vld, r12_vld;
    logic               r11_fault, r12_fault;
    logic signed [15:0] r11_t, r12_t;
    logic signed [31:0] r11_p0, r12_p0;
    logic signed [47:0] r11_y1sq;
    logic signed [45:0] r11_y2p;
    logic        [35:0] r12_y1, r12_y2;
    logic signed [23:0] w11_a;
    logic signed [60:0] w12_y1;
    logic        [35:0] w13_corr;
    t_bcu_out           r_out;

    assign w11_a    = w_p0[31:8];
    assign w12_y1   = 61'(r11_y1sq) * 61'(Y1_COEF);
    assign w13_corr = r12_y1 + r12_y2 + P_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld   <= 1'b0;
            r12_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r11_vld   <= d2_vld;
            r12_vld   <= r11_vld;
            r_out_vld <= r12_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_y1sq  <= w11_a * w11_a;
            r11_y2p   <= 46'(Y2_COEF) * 46'(w_p0);
            r11_p0    <= w_p0;
            r11_t     <= d2_t;
            r11_fault <= d2_fault;

            r12_y1    <= w12_y1[51:16];
            // Y2 is negative for positive P0, so carry its sign up
            r12_y2    <= 36'($signed(r11_y2p[45:16]));
            r12_p0    <= r11_p0;
            r12_t     <= r11_t;
            r12_fault <= r11_fault;

            // zero both results on a divide fault
            if (r12_fault) begin
                r_out.temperature_tenths <= '0;
                r_out.pressure_pa        <= '0;
                r_out.divide_fault       <= 1'b1;
            end else begin
                r_out.temperature_tenths <= r12_t;
                r_out.pressure_pa        <= r12_p0 + $signed(w13_corr[35:4]);
                r_out.divide_fault       <= 1'b0;
            end
        end
    end

    assign o_data = r_out;

endmodule

[sv/bcu_regs.sv]
module bcu_regs
    import bcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_bcu_cal    o_cal
);

    t_bcu_cal r_cal;
    t_bcu_reg w_sel;

    assign w_sel  = t_bcu_reg'(paddr[5:3]);
    assign pready = 1'b1;
    assign o_cal  = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.ac_first     <= '0;
            r_cal.ac_second    <= '0;
            r_cal.b_pair       <= '0;
            r_cal.m_pair       <= '0;
            r_cal.oversampling <= OSS_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_sel)
                REG_AC_FIRST:  r_cal.ac_first     <= pwdata[47:0];
                REG_AC_SECOND: r_cal.ac_second    <= pwdata[47:0];
                REG_B_PAIR:    r_cal.b_pair       <= pwdata[31:0];
                REG_M_PAIR:    r_cal.m_pair       <= pwdata[31:0];
                REG_OSS:       r_cal.oversampling <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_AC_FIRST:  prdata = {16'd0, r_cal.ac_first};
            REG_AC_SECOND: prdata = {16'd0, r_cal.ac_second};
            REG_B_PAIR:    prdata = {32'd0, r_cal.b_pair};
            REG_M_PAIR:    prdata = {32'd0, r_cal.m_pair};
            REG_OSS:       prdata = {62'd0, r_cal.oversampling};
            default:       prdata = '0;
        endcase
    end

endmodule

[sv/bcu_div.sv]
module bcu_div #(
    parameter int NW  = 32,
    parameter int DW  = 17,
    parameter int SW  = 1,
    parameter int BPS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int NS = (NW + BPS - 1) / BPS;
    localparam int NP = NS * BPS;

    logic [DW-1:0] r_rem  [NS];
    logic [NP-1:0] r_num  [NS];
    logic [DW-1:0] r_den  [NS];
    logic [SW-1:0] r_side [NS];
    logic          r_vld  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [DW-1:0] a_rem;
        logic [NP-1:0] a_num;
        logic [DW-1:0] a_den;
        logic [SW-1:0] a_side;
        logic          a_vld;
        logic [DW-1:0] n_rem;
        logic [NP-1:0] n_num;

        if (k == 0) begin : g_in
            assign a_rem  = '0;
            assign a_num  = NP'(i_num);
            assign a_den  = i_den;
            assign a_side = i_side;
            assign a_vld  = i_valid;
        end else begin : g_mid
            assign a_rem  = r_rem[k-1];
            assign a_num  = r_num[k-1];
            assign a_den  = r_den[k-1];
            assign a_side = r_side[k-1];
            assign a_vld  = r_vld[k-1];
        end

        // restoring steps: shift in a numerator bit, subtract when it fits
        always_comb begin
            logic [DW:0] v_t;
            n_rem = a_rem;
            n_num = a_num;
            for (int b = 0; b < BPS; b++) begin
                v_t = {n_rem, n_num[NP-1]};
                if (v_t >= {1'b0, a_den}) begin
                    n_rem = DW'(v_t - {1'b0, a_den});
                    n_num = {n_num[NP-2:0], 1'b1};
                end else begin
                    n_rem = v_t[DW-1:0];
                    n_num = {n_num[NP-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= n_num;
                r_den[k]  <= a_den;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_num[NS-1][NW-1:0];
    assign o_side  = r_side[NS-1];

endmodule
